### rtl/lae_pkg.sv
// shared types, constants and helper functions of the led animation engine
`default_nettype none

package lae_pkg;

    localparam int MAX_COLORS = 8;
    localparam int NUM_LEDS   = 6;
    localparam int COLOR_CAP  = (MAX_COLORS < 8) ? MAX_COLORS : 8;

    localparam int LED_W      = 6;
    localparam int CH_W       = 8;
    localparam int PER_W      = 16;
    localparam int CNT_W      = 4;
    localparam int CODES_W    = 24;
    localparam int SLOT_W     = 3;
    localparam int CODE_W     = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIVQ_W     = PER_W + 1;
    localparam int ITER_W     = $clog2(DIVQ_W + 1);
    localparam int PROD_W     = PER_W + CNT_W;
    localparam int FRAC_BITS  = 8;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int MIX_W      = CH_W + FRAC_W;

    localparam logic [CNT_W-1:0]  N_CAP    = CNT_W'(COLOR_CAP);
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_BITS);
    localparam logic [LED_W-1:0]  LED_KEEP = (NUM_LEDS >= LED_W) ? {LED_W{1'b1}}
                                           : LED_W'((64'd1 << NUM_LEDS) - 64'd1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd6;

    // animation modes
    localparam logic [MODE_W-1:0] MODE_SNAP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FADE = 2'd1;

    // palette codes
    localparam logic [CODE_W-1:0] COL_BLACK  = 3'd0;
    localparam logic [CODE_W-1:0] COL_RED    = 3'd1;
    localparam logic [CODE_W-1:0] COL_GREEN  = 3'd2;
    localparam logic [CODE_W-1:0] COL_BLUE   = 3'd3;
    localparam logic [CODE_W-1:0] COL_YELLOW = 3'd4;
    localparam logic [CODE_W-1:0] COL_WHITE  = 3'd5;
    localparam logic [CODE_W-1:0] COL_ORANGE = 3'd6;

    localparam logic [CH_W-1:0] CH_FULL = 8'd255;
    localparam logic [CH_W-1:0] CH_HALF = 8'd128;

    // channel sequence of the blend step
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEG,
        S_LEN,
        S_CHK,
        S_MOD,
        S_STEP,
        S_FSET,
        S_FRAC,
        S_MIX,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [PER_W-1:0]  rem_init;
        logic [DIVQ_W-1:0] dq_init;
        logic [PER_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVQ_W-1:0] quot;
        logic [PER_W-1:0]  rem;
    } t_div_rsp;

    function automatic logic [CNT_W-1:0] used_colors(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] n;
        n = count;
        if (count == '0) begin
            n = CNT_W'(1);
        end else if (count > N_CAP) begin
            n = N_CAP;
        end
        return n;
    endfunction

    function automatic logic [CODE_W-1:0] slot_code(input logic [CODES_W-1:0] codes,
                                                    input logic [SLOT_W-1:0]  slot);
        return codes[CODE_W*int'(slot) +: CODE_W];
    endfunction

    function automatic t_rgb code_rgb(input logic [CODE_W-1:0] code);
        t_rgb c;
        c = '0;
        unique case (code)
            COL_BLACK:  c = '0;
            COL_RED:    c.red = CH_FULL;
            COL_GREEN:  c.green = CH_FULL;
            COL_BLUE:   c.blue = CH_FULL;
            COL_YELLOW: begin
                c.red   = CH_FULL;
                c.green = CH_FULL;
            end
            COL_WHITE: begin
                c.red   = CH_FULL;
                c.green = CH_FULL;
                c.blue  = CH_FULL;
            end
            COL_ORANGE: begin
                c.red   = CH_FULL;
                c.green = CH_HALF;
            end
            default:    c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/lae_ifs.sv
// valid/ready channel interfaces for tick items and color result items
`default_nettype none

interface lae_in_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink (input valid, input advance, output ready);
endinterface

interface lae_out_if;
    logic                          valid;
    logic                          ready;
    logic [lae_pkg::LED_W-1:0]     target_leds;
    logic [lae_pkg::CH_W-1:0]      red;
    logic [lae_pkg::CH_W-1:0]      green;
    logic [lae_pkg::CH_W-1:0]      blue;

    modport source (output valid, output target_leds, output red, output green,
                    output blue, input ready);
    modport sink (input valid, input target_leds, input red, input green,
                  input blue, output ready);
endinterface

`default_nettype wire

### rtl/lae_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module lae_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lae_pkg::t_div_req i_req,
    output lae_pkg::t_div_rsp o_rsp
);

    logic                                r_busy, n_busy;
    logic                                r_done, n_done;
    logic [lae_pkg::ITER_W-1:0]          r_cnt, n_cnt;
    logic [lae_pkg::PER_W-1:0]           r_rem, n_rem;
    logic [lae_pkg::DIVQ_W-1:0]          r_dq, n_dq;
    logic [lae_pkg::PER_W-1:0]           r_div, n_div;

    logic [lae_pkg::PER_W:0]             w_sh;
    logic [lae_pkg::PER_W:0]             w_diff;
    logic                                w_ge;

    // partial remainder shifted by one dividend bit
    assign w_sh   = {r_rem, r_dq[lae_pkg::DIVQ_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_div});
    assign w_diff = w_sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dq   = r_dq;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.iters;
            n_rem  = i_req.rem_init;
            n_dq   = i_req.dq_init;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[lae_pkg::PER_W-1:0] : w_sh[lae_pkg::PER_W-1:0];
            n_dq  = {r_dq[lae_pkg::DIVQ_W-2:0], w_ge};
            n_cnt = r_cnt - lae_pkg::ITER_W'(1);
            if (r_cnt == lae_pkg::ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_div <= n_div;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dq;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

### rtl/led_animation_engine_core.sv
// top level of the led animation engine: registers, tick sequencer, blend and output stage
// Each accepted tick item drives one step of an RGB LED animation and yields at most one
// color item for the LEDs in led_mask. Snap mode shows palette slot 0 solid when one color
// is in use, or blinks slots 0 and 1 after an optional start offset when two are in use; fade
// mode walks the palette and blends each color linearly into the next with a Q1.8 fraction.
// One item is worked on at a time; the input is ready again once the result sits in the
// output register, which holds it until taken. How long a tick takes is set by one shared
// bit-serial divider (17 steps) that a fade tick may run twice, for the segment length and
// for the position inside the segment, plus an 8-step run for the blend fraction and a
// channel-serial blend over red, green and blue. Registers are written through the plain
// write port and are meant to change only while no tick is in flight.
`default_nettype none

module led_animation_engine_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lae_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lae_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lae_in_if.sink                             i_in,
    lae_out_if.source                          o_out
);

    // configuration registers
    logic                            r_enable;
    logic [lae_pkg::MODE_W-1:0]      r_mode;
    logic [lae_pkg::PER_W-1:0]       r_period;
    logic [lae_pkg::PER_W-1:0]       r_offset;
    logic [lae_pkg::CNT_W-1:0]       r_count;
    logic [lae_pkg::CODES_W-1:0]     r_codes;
    logic [lae_pkg::LED_W-1:0]       r_mask;

    // animation state
    lae_pkg::t_state                 r_state, n_state;
    logic [lae_pkg::PER_W-1:0]       r_cycle, n_cycle;
    logic [lae_pkg::PER_W-1:0]       r_seg, n_seg;
    logic [lae_pkg::SLOT_W-1:0]      r_cur, n_cur;
    logic [lae_pkg::SLOT_W-1:0]      r_next, n_next;
    logic                            r_pend, n_pend;
    logic                            r_fade, n_fade;

    // per-item working registers
    logic [lae_pkg::PER_W-1:0]       r_len, n_len;
    logic [lae_pkg::FRAC_W-1:0]      r_frac, n_frac;
    logic [1:0]                      r_ch, n_ch;
    lae_pkg::t_rgb                   r_res, n_res;

    // output register
    logic                            r_ovalid, n_ovalid;
    logic [lae_pkg::LED_W-1:0]       r_oleds, n_oleds;
    lae_pkg::t_rgb                   r_orgb, n_orgb;

    lae_pkg::t_div_req               w_req;
    lae_pkg::t_div_rsp               w_rsp;

    logic                            w_acc;
    logic                            w_ofree;
    logic [lae_pkg::CNT_W-1:0]       w_n;
    logic [lae_pkg::CNT_W-1:0]       w_n1;
    logic [lae_pkg::PER_W-1:0]       w_c1;
    logic                            w_restart;
    logic [lae_pkg::PROD_W-1:0]      w_prod;
    logic [lae_pkg::SLOT_W-1:0]      w_cnew;
    logic [lae_pkg::SLOT_W-1:0]      w_adv_cur;
    logic [lae_pkg::SLOT_W-1:0]      w_adv_next;
    lae_pkg::t_rgb                   w_slot0_rgb;
    lae_pkg::t_rgb                   w_cur_rgb;
    lae_pkg::t_rgb                   w_next_rgb;
    logic [lae_pkg::CH_W-1:0]        w_a;
    logic [lae_pkg::CH_W-1:0]        w_b;
    logic [lae_pkg::MIX_W-1:0]       w_mix;

    lae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // register write port, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_mode   <= lae_pkg::MODE_SNAP;
            r_period <= lae_pkg::PER_W'(1);
            r_offset <= '0;
            r_count  <= lae_pkg::CNT_W'(1);
            r_codes  <= '0;
            r_mask   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lae_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                lae_pkg::CFG_MODE:   r_mode   <= i_cfg_data[lae_pkg::MODE_W-1:0];
                lae_pkg::CFG_PERIOD: r_period <= i_cfg_data[lae_pkg::PER_W-1:0];
                lae_pkg::CFG_OFFSET: r_offset <= i_cfg_data[lae_pkg::PER_W-1:0];
                lae_pkg::CFG_COUNT:  r_count  <= i_cfg_data[lae_pkg::CNT_W-1:0];
                lae_pkg::CFG_CODES:  r_codes  <= i_cfg_data[lae_pkg::CODES_W-1:0];
                lae_pkg::CFG_MASK:   r_mask   <= i_cfg_data[lae_pkg::LED_W-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign i_in.ready = (r_state == lae_pkg::S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_ofree    = !r_ovalid || o_out.ready;

    // colors in use, clamped to the palette size
    assign w_n  = lae_pkg::used_colors(r_count);
    assign w_n1 = w_n - lae_pkg::CNT_W'(1);

    assign w_c1      = r_cycle + lae_pkg::PER_W'(1);
    // a new cycle starts at count zero or once the period is used up
    assign w_restart = (r_cycle == '0) || (r_cycle >= r_period);
    assign w_prod    = lae_pkg::PROD_W'(r_seg) * lae_pkg::PROD_W'(w_n);

    // slot advance at a segment boundary: blink jumps to the second color,
    // fade moves on and wraps the blend target at the end of the palette
    assign w_cnew = r_cur + lae_pkg::SLOT_W'(1);
    always_comb begin
        if (r_fade) begin
            w_adv_cur  = w_cnew;
            w_adv_next = ({1'b0, w_cnew} >= w_n1) ? '0 : (w_cnew + lae_pkg::SLOT_W'(1));
        end else begin
            w_adv_cur  = lae_pkg::SLOT_W'(1);
            w_adv_next = r_next;
        end
    end

    assign w_slot0_rgb = lae_pkg::code_rgb(lae_pkg::slot_code(r_codes, '0));
    assign w_cur_rgb   = lae_pkg::code_rgb(lae_pkg::slot_code(r_codes, r_cur));
    assign w_next_rgb  = lae_pkg::code_rgb(lae_pkg::slot_code(r_codes, r_next));

    // one channel of the blend per cycle
    always_comb begin
        unique case (r_ch)
            lae_pkg::CH_RED: begin
                w_a = w_cur_rgb.red;
                w_b = w_next_rgb.red;
            end
            lae_pkg::CH_GREEN: begin
                w_a = w_cur_rgb.green;
                w_b = w_next_rgb.green;
            end
            default: begin
                w_a = w_cur_rgb.blue;
                w_b = w_next_rgb.blue;
            end
        endcase
    end

    // cur*(1-f) + next*f, rounded
    assign w_mix = lae_pkg::MIX_W'(w_a) * lae_pkg::MIX_W'(lae_pkg::FRAC_ONE - r_frac)
                 + lae_pkg::MIX_W'(w_b) * lae_pkg::MIX_W'(r_frac)
                 + lae_pkg::MIX_W'(lae_pkg::CH_HALF);

    // tick sequencer
    always_comb begin
        n_state  = r_state;
        n_cycle  = r_cycle;
        n_seg    = r_seg;
        n_cur    = r_cur;
        n_next   = r_next;
        n_pend   = r_pend;
        n_fade   = r_fade;
        n_len    = r_len;
        n_frac   = r_frac;
        n_ch     = r_ch;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        n_oleds  = r_oleds;
        n_orgb   = r_orgb;
        w_req    = '0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            lae_pkg::S_IDLE: begin
                if (w_acc && i_in.advance && r_enable) begin
                    if (r_mode == lae_pkg::MODE_SNAP) begin
                        if (w_n == lae_pkg::CNT_W'(1)) begin
                            // solid color, no state change
                            n_res   = w_slot0_rgb;
                            n_state = lae_pkg::S_EMIT;
                        end else if (w_n == lae_pkg::CNT_W'(2)) begin
                            n_fade = 1'b0;
                            if (r_pend) begin
                                // start offset: count ticks with no output
                                if ((r_offset != '0) && (w_c1 < r_offset)) begin
                                    n_cycle = w_c1;
                                end else begin
                                    n_pend  = 1'b0;
                                    n_cycle = '0;
                                    n_state = lae_pkg::S_SEG;
                                end
                            end else begin
                                n_state = lae_pkg::S_SEG;
                            end
                        end
                    end else if (r_mode == lae_pkg::MODE_FADE) begin
                        n_fade  = 1'b1;
                        n_state = lae_pkg::S_SEG;
                    end
                end
            end

            lae_pkg::S_SEG: begin
                if (w_restart) begin
                    n_cur   = '0;
                    n_cycle = '0;
                    n_seg   = '0;
                    if (r_fade) begin
                        n_next = (w_n > lae_pkg::CNT_W'(1)) ? lae_pkg::SLOT_W'(1) : '0;
                    end
                    n_state = lae_pkg::S_STEP;
                end else if (r_fade) begin
                    // segment length ceil(period / colors)
                    w_req.start    = 1'b1;
                    w_req.rem_init = '0;
                    w_req.dq_init  = lae_pkg::DIVQ_W'(r_period) + lae_pkg::DIVQ_W'(w_n)
                                   - lae_pkg::DIVQ_W'(1);
                    w_req.divisor  = lae_pkg::PER_W'(w_n);
                    w_req.iters    = lae_pkg::ITER_W'(lae_pkg::DIVQ_W);
                    n_state        = lae_pkg::S_LEN;
                end else begin
                    // blink half period, rounded up
                    n_len   = lae_pkg::PER_W'((lae_pkg::DIVQ_W'(r_period)
                                               + lae_pkg::DIVQ_W'(1)) >> 1);
                    n_state = lae_pkg::S_CHK;
                end
            end

            lae_pkg::S_LEN: begin
                if (w_rsp.done) begin
                    n_len   = (w_rsp.quot == '0) ? lae_pkg::PER_W'(1)
                                                 : w_rsp.quot[lae_pkg::PER_W-1:0];
                    n_state = lae_pkg::S_CHK;
                end
            end

            lae_pkg::S_CHK: begin
                if (r_seg < r_len) begin
                    // short segment count: remainder is the count itself
                    if (r_seg == '0) begin
                        n_cur  = w_adv_cur;
                        n_next = w_adv_next;
                        n_seg  = '0;
                    end
                    n_state = lae_pkg::S_STEP;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.rem_init = '0;
                    w_req.dq_init  = {1'b0, r_seg};
                    w_req.divisor  = r_len;
                    w_req.iters    = lae_pkg::ITER_W'(lae_pkg::DIVQ_W);
                    n_state        = lae_pkg::S_MOD;
                end
            end

            lae_pkg::S_MOD: begin
                if (w_rsp.done) begin
                    if (w_rsp.rem == '0) begin
                        n_cur  = w_adv_cur;
                        n_next = w_adv_next;
                        n_seg  = '0;
                    end
                    n_state = lae_pkg::S_STEP;
                end
            end

            lae_pkg::S_STEP: begin
                n_cycle = w_c1;
                n_seg   = r_seg + lae_pkg::PER_W'(1);
                if (r_fade) begin
                    n_state = lae_pkg::S_FSET;
                end else begin
                    n_res   = w_cur_rgb;
                    n_state = lae_pkg::S_EMIT;
                end
            end

            lae_pkg::S_FSET: begin
                n_ch = lae_pkg::CH_RED;
                // fraction saturates at one once seg*n reaches the period,
                // and always for a zero period
                if (w_prod >= lae_pkg::PROD_W'(r_period)) begin
                    n_frac  = lae_pkg::FRAC_ONE;
                    n_state = lae_pkg::S_MIX;
                end else begin
                    w_req.start    = 1'b1;
                    w_req.rem_init = w_prod[lae_pkg::PER_W-1:0];
                    w_req.dq_init  = '0;
                    w_req.divisor  = r_period;
                    w_req.iters    = lae_pkg::ITER_W'(lae_pkg::FRAC_BITS);
                    n_state        = lae_pkg::S_FRAC;
                end
            end

            lae_pkg::S_FRAC: begin
                if (w_rsp.done) begin
                    n_frac  = {1'b0, w_rsp.quot[lae_pkg::FRAC_BITS-1:0]};
                    n_state = lae_pkg::S_MIX;
                end
            end

            lae_pkg::S_MIX: begin
                unique case (r_ch)
                    lae_pkg::CH_RED:   n_res.red   = w_mix[lae_pkg::FRAC_BITS +: lae_pkg::CH_W];
                    lae_pkg::CH_GREEN: n_res.green = w_mix[lae_pkg::FRAC_BITS +: lae_pkg::CH_W];
                    default:           n_res.blue  = w_mix[lae_pkg::FRAC_BITS +: lae_pkg::CH_W];
                endcase
                if (r_ch == lae_pkg::CH_BLUE) begin
                    n_state = lae_pkg::S_EMIT;
                end else begin
                    n_ch = r_ch + 2'd1;
                end
            end

            lae_pkg::S_EMIT: begin
                // hand the item over once the output register is free
                if (w_ofree) begin
                    n_ovalid = 1'b1;
                    n_oleds  = r_mask & lae_pkg::LED_KEEP;
                    n_orgb   = r_res;
                    n_state  = lae_pkg::S_IDLE;
                end
            end

            default: n_state = lae_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lae_pkg::S_IDLE;
            r_cycle  <= '0;
            r_seg    <= '0;
            r_cur    <= '0;
            r_next   <= lae_pkg::SLOT_W'(1);
            r_pend   <= 1'b1;
            r_fade   <= 1'b0;
            r_ch     <= lae_pkg::CH_RED;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cycle  <= n_cycle;
            r_seg    <= n_seg;
            r_cur    <= n_cur;
            r_next   <= n_next;
            r_pend   <= n_pend;
            r_fade   <= n_fade;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_frac  <= n_frac;
        r_res   <= n_res;
        r_oleds <= n_oleds;
        r_orgb  <= n_orgb;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.target_leds = r_oleds;
    assign o_out.red         = r_orgb.red;
    assign o_out.green       = r_orgb.green;
    assign o_out.blue        = r_orgb.blue;

endmodule

`default_nettype wire

### dv/tb_led_animation_engine_core.sv
// self-checking testbench of the led animation engine core: directed table then random phases
`timescale 1ns / 1ps

module tb_led_animation_engine_core;
    import lae_pkg::*;

    // codes the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;
    localparam logic [CODE_W-1:0] CODE_UNDEF = 3'd7;

    // palettes of the directed part, slot 0 in the low bits
    localparam logic [CODES_W-1:0] CODES_MIX = {COL_WHITE, COL_YELLOW, CODE_UNDEF, COL_BLUE,
                                                COL_GREEN, COL_BLACK, COL_ORANGE, COL_RED};
    localparam logic [CODES_W-1:0] CODES_UNDEF = {8{CODE_UNDEF}};

    // leave margin for the slowest fade tick before touching registers
    localparam int DRAIN_CYCLES  = 90;
    localparam int PHASE_RESULTS = 585;
    localparam int MAX_SHOWN     = 10;

    typedef struct packed {
        logic [LED_W-1:0] leds;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } led_color_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;
    typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_MODEL} row_chk_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  adv;
        row_chk_t              chk;
        led_color_t            want;
    } stim_row_t;

    // clock, reset and the plain register write port
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lae_in_if  tick_ch ();
    lae_out_if color_ch ();

    led_animation_engine_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (tick_ch),
        .o_out      (color_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow registers, reset values as the block has them
    logic                  r_enable;
    logic [MODE_W-1:0]     r_mode;
    logic [PER_W-1:0]      r_period;
    logic [PER_W-1:0]      r_offset;
    logic [CNT_W-1:0]      r_count;
    logic [CODES_W-1:0]    r_codes;
    logic [LED_W-1:0]      r_mask;

    // animation state of the predictor
    logic [PER_W-1:0]      anim_cyc;
    logic [PER_W-1:0]      anim_seg;
    logic [SLOT_W-1:0]     anim_cur;
    logic [SLOT_W-1:0]     anim_nxt;
    logic                  anim_off_wait;

    led_color_t color_q[$];
    stim_row_t  dir_rows[$];

    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned err_cnt;
    int unsigned ticks_sent;
    int unsigned colors_checked;
    int unsigned reg_writes;
    bit          tick_since_cfg;

    led_color_t mon_got;
    led_color_t mon_exp;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE: r_enable = data[0];
            CFG_MODE:   r_mode   = data[MODE_W-1:0];
            CFG_PERIOD: r_period = data[PER_W-1:0];
            CFG_OFFSET: r_offset = data[PER_W-1:0];
            CFG_COUNT:  r_count  = data[CNT_W-1:0];
            CFG_CODES:  r_codes  = data[CODES_W-1:0];
            CFG_MASK:   r_mask   = data[LED_W-1:0];
            default: ;
        endcase
    endfunction

    // zero counts as one, anything above the palette depth is capped
    function automatic int unsigned colors_in_use();
        int unsigned n;
        n = r_count;
        if (n < 1) n = 1;
        if (n > COLOR_CAP) n = COLOR_CAP;
        return n;
    endfunction

    function automatic t_rgb palette_rgb(input logic [SLOT_W-1:0] slot);
        logic [CODE_W-1:0] code;
        t_rgb              c;
        code = r_codes[int'(slot)*CODE_W +: CODE_W];
        c = '0;
        case (code)
            COL_RED:    c.red = CH_FULL;
            COL_GREEN:  c.green = CH_FULL;
            COL_BLUE:   c.blue = CH_FULL;
            COL_YELLOW: begin
                c.red   = CH_FULL;
                c.green = CH_FULL;
            end
            COL_WHITE: begin
                c.red   = CH_FULL;
                c.green = CH_FULL;
                c.blue  = CH_FULL;
            end
            COL_ORANGE: begin
                c.red   = CH_FULL;
                c.green = CH_HALF;
            end
            default: c = '0;    // black and the undefined code
        endcase
        return c;
    endfunction

    function automatic led_color_t make_color(input t_rgb c);
        led_color_t r;
        r.leds  = r_mask & LED_W'((64'd1 << NUM_LEDS) - 64'd1);
        r.red   = c.red;
        r.green = c.green;
        r.blue  = c.blue;
        return r;
    endfunction

    function automatic int unsigned seg_ticks(input int unsigned n);
        int unsigned l;
        l = (int'(r_period) + n - 1) / n;
        return (l != 0) ? l : 1;
    endfunction

    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input int unsigned f);
        int unsigned v;
        v = (int'(a) * (256 - f) + int'(b) * f + 128) >> 8;
        return v[CH_W-1:0];
    endfunction

    function automatic bit blink_tick(output led_color_t c);
        // the start offset runs once after reset, then the cycle begins on that tick
        if (anim_off_wait) begin
            if (r_offset != '0) begin
                anim_cyc = anim_cyc + 1'b1;
                if (anim_cyc < r_offset) return 1'b0;
            end
            anim_off_wait = 1'b0;
            anim_cyc = '0;
        end
        if (anim_cyc == '0 || anim_cyc >= r_period) begin
            anim_cur = '0;
            anim_cyc = '0;
            anim_seg = '0;
        end else if ((int'(anim_seg) % seg_ticks(2)) == 0) begin
            anim_cur = 3'd1;
            anim_seg = '0;
        end
        c = make_color(palette_rgb(anim_cur));
        anim_cyc = anim_cyc + 1'b1;
        anim_seg = anim_seg + 1'b1;
        return 1'b1;
    endfunction

    function automatic bit fade_tick(output led_color_t c);
        int unsigned n;
        int unsigned f;
        t_rgb        a;
        t_rgb        b;
        t_rgb        m;
        n = colors_in_use();
        if (anim_cyc == '0 || anim_cyc >= r_period) begin
            anim_cur = '0;
            anim_cyc = '0;
            anim_seg = '0;
            anim_nxt = (n > 1) ? 3'd1 : 3'd0;
        end else if ((int'(anim_seg) % seg_ticks(n)) == 0) begin
            // slots wrap at 3 bits, a slot past the palette may show after a count change
            anim_cur = anim_cur + 1'b1;
            anim_nxt = anim_cur + 1'b1;
            anim_seg = '0;
            if (int'(anim_cur) >= n - 1) anim_nxt = '0;
        end
        anim_cyc = anim_cyc + 1'b1;
        anim_seg = anim_seg + 1'b1;
        // q1.8 fraction, a zero period means a full step to the next color
        if (r_period == '0) begin
            f = 256;
        end else begin
            f = (int'(anim_seg) * n * 256) / int'(r_period);
            if (f > 256) f = 256;
        end
        a = palette_rgb(anim_cur);
        b = palette_rgb(anim_nxt);
        m.red   = blend_ch(a.red, b.red, f);
        m.green = blend_ch(a.green, b.green, f);
        m.blue  = blend_ch(a.blue, b.blue, f);
        c = make_color(m);
        return 1'b1;
    endfunction

    // one accepted tick item, returns whether a color item follows
    function automatic bit animate_tick(input logic adv, output led_color_t c);
        int unsigned n;
        if (!adv || !r_enable) return 1'b0;
        n = colors_in_use();
        if (r_mode == MODE_SNAP) begin
            if (n == 1) begin
                c = make_color(palette_rgb(3'd0));
                return 1'b1;
            end
            if (n == 2) return blink_tick(c);
            return 1'b0;    // snap has no meaning for more than two colors
        end
        if (r_mode == MODE_FADE) return fade_tick(c);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    function automatic bit coin(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // registers only change with nothing in flight; a tick may still be working
    // on no result at all, so give it the full tick latency after the queue drains
    task automatic wait_idle();
        tick_ch.valid <= 1'b0;
        while (color_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tick_since_cfg = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (tick_since_cfg) wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        shadow_write(idx, data);
        reg_writes++;
        // drop the enable for a cycle so back-to-back writes never collide
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_tick(input logic adv, output bit has, output led_color_t c);
        while (coin(send_idle)) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.advance <= adv;
        @(posedge i_clk);
        while (tick_ch.ready !== 1'b1) @(posedge i_clk);
        has = animate_tick(adv, c);
        ticks_sent++;
        tick_since_cfg = 1'b1;
    endtask

    // mostly data bits only, now and then junk above the register width
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int unsigned width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << width) - 1'b1;
        if (coin(10)) return (v & keep) | (CFG_DATA_W'($urandom) & ~keep);
        return v & keep;
    endfunction

    task automatic shuffle_regs();
        logic [CFG_DATA_W-1:0] v;
        if (coin(50)) write_reg(CFG_ENABLE, with_junk(coin(92) ? 24'd1 : 24'd0, 1));
        if (coin(60)) begin
            case ($urandom_range(19))
                0:       v = MODE_OFF;
                1:       v = MODE_RSVD;
                2, 3, 4, 5, 6, 7, 8, 9, 10: v = MODE_SNAP;
                default: v = MODE_FADE;
            endcase
            write_reg(CFG_MODE, with_junk(v, MODE_W));
        end
        if (coin(60)) begin
            // short periods so the cycle wraps often, extremes now and then
            case ($urandom_range(9))
                0:       v = 24'd0;
                1:       v = 24'hFFFF;
                2:       v = $urandom_range(65535);
                default: v = $urandom_range(1, 24);
            endcase
            write_reg(CFG_PERIOD, with_junk(v, PER_W));
        end
        if (coin(20)) begin
            case ($urandom_range(2))
                0:       v = 24'd0;
                1:       v = 24'hFFFF;
                default: v = $urandom_range(65535);
            endcase
            write_reg(CFG_OFFSET, with_junk(v, PER_W));
        end
        if (coin(60)) begin
            case ($urandom_range(9))
                0, 1, 2: v = 24'd1;
                3, 4, 5: v = 24'd2;
                default: v = $urandom_range(15);
            endcase
            write_reg(CFG_COUNT, with_junk(v, CNT_W));
        end
        if (coin(50)) begin
            case ($urandom_range(9))
                0:       v = 24'd0;
                1:       v = CODES_UNDEF;
                default: v = $urandom;
            endcase
            write_reg(CFG_CODES, v);
        end
        if (coin(40)) begin
            case ($urandom_range(5))
                0:       v = 24'd0;
                1:       v = 24'd63;
                default: v = $urandom_range(63);
            endcase
            write_reg(CFG_MASK, with_junk(v, LED_W));
        end
    endtask

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        r.adv  = 1'b0;
        r.chk  = CHK_NONE;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t tick_row(input logic adv, input row_chk_t chk,
                                           input logic [LED_W-1:0] leds,
                                           input logic [CH_W-1:0] red,
                                           input logic [CH_W-1:0] green,
                                           input logic [CH_W-1:0] blue);
        stim_row_t r;
        r.kind = ROW_TICK;
        r.idx  = '0;
        r.data = '0;
        r.adv  = adv;
        r.chk  = chk;
        r.want = '{leds, red, green, blue};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    always @(posedge i_clk) color_ch.ready <= !coin(recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && color_ch.valid && color_ch.ready) begin
            mon_got = '{color_ch.target_leds, color_ch.red, color_ch.green, color_ch.blue};
            if (color_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("%0t: color item with none expected: leds=%h r=%0d g=%0d b=%0d",
                             $realtime, mon_got.leds, mon_got.red, mon_got.green,
                             mon_got.blue);
            end else begin
                mon_exp = color_q.pop_front();
                colors_checked++;
                if (mon_got !== mon_exp) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display({"%0t: color item mismatch: expected leds=%h r=%0d g=%0d b=%0d,",
                                  " got leds=%h r=%0d g=%0d b=%0d"}, $realtime,
                                 mon_exp.leds, mon_exp.red, mon_exp.green, mon_exp.blue,
                                 mon_got.leds, mon_got.red, mon_got.green, mon_got.blue);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    int unsigned send_pct[3] = '{10, 69, 0};
    int unsigned recv_pct[3] = '{69, 10, 0};

    initial begin : main_seq
        int unsigned phase_colors;
        int unsigned n_ticks;
        int unsigned guard;
        bit          has;
        led_color_t  c;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        tick_ch.valid   = 1'b0;
        tick_ch.advance = 1'b0;
        color_ch.ready  = 1'b0;
        send_idle       = send_pct[0];
        recv_idle       = recv_pct[0];
        err_cnt         = 0;
        ticks_sent      = 0;
        colors_checked  = 0;
        reg_writes      = 0;
        tick_since_cfg  = 1'b0;

        r_enable      = 1'b0;
        r_mode        = MODE_SNAP;
        r_period      = 16'd1;
        r_offset      = '0;
        r_count       = 4'd1;
        r_codes       = '0;
        r_mask        = '0;
        anim_cyc      = '0;
        anim_seg      = '0;
        anim_cur      = '0;
        anim_nxt      = 3'd1;
        anim_off_wait = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed rows carry what can be read off directly
        dir_rows.push_back(tick_row(1'b1, CHK_NONE, '0, '0, '0, '0));    // disabled after reset
        dir_rows.push_back(reg_row(CFG_MASK, 24'd63));
        dir_rows.push_back(reg_row(CFG_CODES, CODES_MIX));
        dir_rows.push_back(reg_row(CFG_ENABLE, 24'd1));
        dir_rows.push_back(tick_row(1'b0, CHK_NONE, '0, '0, '0, '0));    // no tick
        dir_rows.push_back(tick_row(1'b1, CHK_TYPED, 6'd63, CH_FULL, '0, '0));  // solid red
        dir_rows.push_back(reg_row(CFG_MASK, 24'd0));
        dir_rows.push_back(tick_row(1'b1, CHK_TYPED, 6'd0, CH_FULL, '0, '0));
        dir_rows.push_back(reg_row(CFG_CODES, CODES_UNDEF));
        dir_rows.push_back(tick_row(1'b1, CHK_TYPED, 6'd0, '0, '0, '0)); // undefined code is black
        // blink with a start offset, then the offset lowered under the elapsed count
        dir_rows.push_back(reg_row(CFG_CODES, CODES_MIX));
        dir_rows.push_back(reg_row(CFG_MASK, 24'h2A));
        dir_rows.push_back(reg_row(CFG_PERIOD, 24'd4));
        dir_rows.push_back(reg_row(CFG_OFFSET, 24'd3));
        dir_rows.push_back(reg_row(CFG_COUNT, 24'd2));
        dir_rows.push_back(tick_row(1'b1, CHK_NONE, '0, '0, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_NONE, '0, '0, '0, '0));
        dir_rows.push_back(reg_row(CFG_OFFSET, 24'd1));
        dir_rows.push_back(tick_row(1'b1, CHK_TYPED, 6'h2A, CH_FULL, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        // zero period restarts every tick on the first color
        dir_rows.push_back(reg_row(CFG_PERIOD, 24'd0));
        dir_rows.push_back(tick_row(1'b1, CHK_TYPED, 6'h2A, CH_FULL, '0, '0));
        dir_rows.push_back(reg_row(CFG_PERIOD, 24'hFFFF));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(reg_row(CFG_COUNT, 24'd3));
        dir_rows.push_back(tick_row(1'b1, CHK_NONE, '0, '0, '0, '0));    // snap with three colors
        dir_rows.push_back(reg_row(CFG_COUNT, 24'd0));
        dir_rows.push_back(tick_row(1'b1, CHK_TYPED, 6'h2A, CH_FULL, '0, '0));  // count zero is one
        // fade, count above the cap, then zero period and a single color
        dir_rows.push_back(reg_row(CFG_MODE, MODE_FADE));
        dir_rows.push_back(reg_row(CFG_COUNT, 24'd15));
        dir_rows.push_back(reg_row(CFG_PERIOD, 24'd16));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(reg_row(CFG_PERIOD, 24'd0));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(reg_row(CFG_COUNT, 24'd1));
        dir_rows.push_back(reg_row(CFG_PERIOD, 24'd5));
        dir_rows.push_back(tick_row(1'b1, CHK_MODEL, '0, '0, '0, '0));
        dir_rows.push_back(reg_row(CFG_MODE, MODE_OFF));
        dir_rows.push_back(tick_row(1'b1, CHK_NONE, '0, '0, '0, '0));
        dir_rows.push_back(reg_row(CFG_MODE, MODE_RSVD));
        dir_rows.push_back(tick_row(1'b1, CHK_NONE, '0, '0, '0, '0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_tick(dir_rows[k].adv, has, c);
                // predictor state still advances on typed rows
                case (dir_rows[k].chk)
                    CHK_TYPED: color_q.push_back(dir_rows[k].want);
                    CHK_MODEL: if (has) color_q.push_back(c);
                    default: ;
                endcase
            end
        end

        // random part: three idle profiles, each a run of register settings with tick bursts
        for (int p = 0; p < 3; p++) begin
            send_idle    = send_pct[p];
            recv_idle    = recv_pct[p];
            phase_colors = 0;
            while (phase_colors < PHASE_RESULTS) begin
                shuffle_regs();
                n_ticks = $urandom_range(3, 40);
                repeat (n_ticks) begin
                    send_tick(!coin(6), has, c);
                    if (has) begin
                        color_q.push_back(c);
                        phase_colors++;
                    end
                end
            end
        end

        // drain, then give a late stray item time to show up
        tick_ch.valid <= 1'b0;
        guard = 0;
        while (color_q.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (color_q.size() != 0) begin
            $display("%0d expected color items never arrived", color_q.size());
            err_cnt += color_q.size();
        end

        $display("ran %0d tick items over %0d register writes, %0d color items compared",
                 ticks_sent, reg_writes, colors_checked);
        $display("covered solid, blink with start offset, fade, zero and full periods, %s",
                 "three idle profiles");
        if (err_cnt == 0) begin
            $display("tb_led_animation_engine_core: clean");
        end else begin
            $display("tb_led_animation_engine_core: errors");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #12_000_000;
        $display("timeout with %0d color items still expected", color_q.size());
        $display("tb_led_animation_engine_core: errors");
        $finish;
    end

endmodule

### sim.f
rtl/lae_pkg.sv
rtl/lae_ifs.sv
rtl/lae_div.sv
rtl/led_animation_engine_core.sv
dv/tb_led_animation_engine_core.sv
